// File: hdl/itoa_pkg.sv
// Shared types, constants and character lookup for the integer to ASCII unit.
// No dependencies; imported by every module of the unit.
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int VALUE_WIDTH_DEFAULT = 32;
  localparam int NUMBER_W            = 32;
  localparam int CHAR_W              = 7;

  // Depth of the queue between classifier and converter
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] OP_UDEC = 2'd0;
  localparam logic [1:0] OP_SDEC = 2'd1;
  localparam logic [1:0] OP_LHEX = 2'd2;
  localparam logic [1:0] OP_UHEX = 2'd3;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

  localparam logic [CHAR_W-1:0] LOWER_DIGITS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };
  localparam logic [CHAR_W-1:0] UPPER_DIGITS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  // Per-word control decoded by the front end
  typedef struct packed {
    logic neg;    // emit a leading minus
    logic hex;    // radix 16, else radix 10
    logic upper;  // upper-case hex letters
  } ctl_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    digit_char = upper ? UPPER_DIGITS[d] : LOWER_DIGITS[d];
  endfunction

endpackage

// File: hdl/itoa_front.sv
// Front end: masks or zero-extends the incoming value, decodes the mode and takes the magnitude.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_front #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic [1:0]                  op,
  input  logic [itoa_pkg::NUMBER_W-1:0] number,
  output itoa_pkg::ctl_t              ctl,
  output logic [VALUE_WIDTH-1:0]      mag
);
  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0] val;

  if (VALUE_WIDTH > NUMBER_W) begin : g_wide
    assign val = {{(VALUE_WIDTH - NUMBER_W){1'b0}}, number};
  end else begin : g_narrow
    assign val = number[VALUE_WIDTH-1:0];
  end

  always_comb begin
    ctl.neg   = (op == OP_SDEC) && val[VALUE_WIDTH-1];
    ctl.hex   = (op == OP_LHEX) || (op == OP_UHEX);
    ctl.upper = (op == OP_UHEX);
    // most negative value wraps onto itself: 2^(W-1) read unsigned
    mag = ctl.neg ? (~val + VALUE_WIDTH'(1)) : val;
  end

endmodule

// File: hdl/itoa_queue.sv
// Short word queue between the front end and the converter.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_queue #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  output logic                   full,
  input  itoa_pkg::ctl_t         wr_ctl,
  input  logic [VALUE_WIDTH-1:0] wr_mag,
  output logic                   q_empty,
  input  logic                   rd_en,
  output itoa_pkg::ctl_t         rd_ctl,
  output logic [VALUE_WIDTH-1:0] rd_mag
);
  import itoa_pkg::*;

  ctl_t                   ctl_q [QUEUE_DEPTH];
  logic [VALUE_WIDTH-1:0] mag_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wr_ptr;
  logic [QPTR_W-1:0]      rd_ptr;
  logic [QCNT_W-1:0]      count;
  logic                   do_wr;
  logic                   do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_ctl  = ctl_q[rd_ptr];
  assign rd_mag  = mag_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      ctl_q[wr_ptr] <= wr_ctl;
      mag_q[wr_ptr] <= wr_mag;
    end
  end

endmodule

// File: hdl/itoa_back.sv
// Back end: bit-serial binary to BCD (or hex) conversion, then character output.
// Depends on itoa_pkg.
`timescale 1ns / 1ps

module itoa_back #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  itoa_pkg::ctl_t              q_ctl,
  input  logic [VALUE_WIDTH-1:0]      q_mag,
  output logic                        empty,
  input  logic                        pop,
  output logic [itoa_pkg::CHAR_W-1:0] character,
  output logic                        last_char
);
  import itoa_pkg::*;

  // decimal digits needed for VALUE_WIDTH bits; always covers the hex digits too
  localparam int NDEC  = (VALUE_WIDTH * 301) / 1000 + 1;
  localparam int DIG_W = NDEC * 4;
  localparam int HI_W  = $clog2(NDEC);
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]             state;
  ctl_t                   ctl;
  logic [VALUE_WIDTH-1:0] sh;
  logic [DIG_W-1:0]       dig;
  logic [HI_W-1:0]        hi;     // index of top nonzero digit
  logic [CNT_W-1:0]       cnt;
  logic                   ovalid;
  logic [CHAR_W-1:0]      ochar;
  logic                   olast;

  logic [DIG_W-1:0]  adj;
  logic [DIG_W-1:0]  shifted;
  logic [HI_W-1:0]   hi_inc;
  logic              hi_up;
  logic [3:0]        cur_dig;
  logic              out_free;
  logic              out_wr;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign out_free  = !ovalid || pop;
  assign empty     = !ovalid;
  assign character = ochar;
  assign last_char = olast;
  assign hi_inc    = hi + 1'b1;

  // add-3 correction on each BCD digit, skipped in hex mode
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      adj[i*4 +: 4] = (!ctl.hex && dig[i*4 +: 4] >= 4'd5) ? dig[i*4 +: 4] + 4'd3
                                                         : dig[i*4 +: 4];
    end
    shifted = {adj[DIG_W-2:0], sh[VALUE_WIDTH-1]};
    // the top nonzero digit moves up by at most one per doubling
    hi_up = 1'b0;
    for (int i = 1; i < NDEC; i++) begin
      if (HI_W'(i) == hi_inc && shifted[i*4 +: 4] != 4'd0) begin
        hi_up = 1'b1;
      end
    end
    cur_dig = 4'd0;
    for (int i = 0; i < NDEC; i++) begin
      if (HI_W'(i) == hi) begin
        cur_dig = dig[i*4 +: 4];
      end
    end
  end

  always_comb begin
    out_wr   = 1'b0;
    out_char = CH_MINUS;
    out_last = 1'b0;
    case (state)
      S_SIGN: begin
        out_wr = out_free;
      end
      S_EMIT: begin
        out_wr   = out_free;
        out_char = digit_char(cur_dig, ctl.upper);
        out_last = (hi == '0);
      end
      default: begin
        out_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            ctl   <= q_ctl;
            sh    <= q_mag;
            dig   <= '0;
            hi    <= '0;
            cnt   <= CNT_W'(VALUE_WIDTH - 1);
            state <= S_CONV;
          end
        end
        S_CONV: begin
          sh  <= {sh[VALUE_WIDTH-2:0], 1'b0};
          dig <= shifted;
          cnt <= cnt - 1'b1;
          if (hi_up) begin
            hi <= hi_inc;
          end
          if (cnt == '0) begin
            state <= ctl.neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (hi == '0) begin
              state <= S_IDLE;
            end else begin
              hi <= hi - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (out_wr) begin
        ovalid <= 1'b1;
        ochar  <= out_char;
        olast  <= out_last;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/integer_to_ascii_digits_unit.sv
// Top level of the integer to ASCII unit: front end, word queue, converter.
// Depends on itoa_pkg, itoa_front, itoa_queue and itoa_back.
`timescale 1ns / 1ps

// Converts one value per input word into its ASCII text, one character per
// output word, most significant digit first with no leading zeros, and
// last_char set on the final character. op selects unsigned decimal, signed
// decimal (a negative value gives '-' then its magnitude), lower-case hex or
// upper-case hex. Both sides are queues: push/full in, empty/pop out. A
// two-word queue sits between the classifier and the converter, so new
// words are taken while an earlier one is still being converted. The
// converter is bit-serial: it loads a word, shifts the value into a digit
// register one bit at a time (double dabble for decimal, plain shift for
// hex), then emits one character at a time, holding while the output
// register is full, and takes no new word until the last character of the
// previous one is written. That serial conversion loop sets the sustained
// rate. Values wider than the 32-bit number port are zero-extended; narrower
// widths use the low VALUE_WIDTH bits, whose top bit is the sign in signed
// mode.
module integer_to_ascii_digits_unit #(
  parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    op,
  input  logic [itoa_pkg::NUMBER_W-1:0] number,
  output logic                          empty,
  input  logic                          pop,
  output logic [itoa_pkg::CHAR_W-1:0]   character,
  output logic                          last_char
);
  import itoa_pkg::*;

  ctl_t                   f_ctl;
  logic [VALUE_WIDTH-1:0] f_mag;
  ctl_t                   q_ctl;
  logic [VALUE_WIDTH-1:0] q_mag;
  logic                   q_empty;
  logic                   q_pop;
  logic                   mid;   // characters of a number are partly delivered

  // classify the incoming word: sign, radix, letter case, magnitude
  itoa_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .op     (op),
    .number (number),
    .ctl    (f_ctl),
    .mag    (f_mag)
  );

  // decouples acceptance from the serial converter
  itoa_queue #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .full    (full),
    .wr_ctl  (f_ctl),
    .wr_mag  (f_mag),
    .q_empty (q_empty),
    .rd_en   (q_pop),
    .rd_ctl  (q_ctl),
    .rd_mag  (q_mag)
  );

  // convert and stream characters through a one-word output register
  itoa_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_ctl     (q_ctl),
    .q_mag     (q_mag),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .last_char (last_char)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (pop && !empty) begin
      mid <= !last_char;
    end
  end

  // a minus sign is never the whole text
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && character == CH_MINUS) |-> !last_char)
    else $error("minus sign flagged as last character");

  // a minus sign only opens a number
  a_minus_first: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && character == CH_MINUS) |-> !mid)
    else $error("minus sign inside a number");

  // the queue only fills through an accepted word
  a_full_after_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push && !full))
    else $error("queue filled without an accepted word");

endmodule
